>>> hdl/ssal_pkg.sv
`default_nettype none
package ssal_pkg;

	localparam int TABLE_DEPTH = 128;
	localparam int ADDR_W      = 32;
	localparam int ETYPE_W     = 16;
	localparam int COUNT_OUT_W = 8;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int GRP         = 8;
	localparam int NGRP        = (TABLE_DEPTH + GRP - 1) / GRP;

	localparam int REG_IDX_W   = 4;
	localparam int REG_DATA_W  = 32;

	localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4 = 16'h0800;

	localparam logic [REG_IDX_W-1:0] REG_SUBNET_BASE = 4'd0;
	localparam logic [REG_IDX_W-1:0] REG_SUBNET_MASK = 4'd1;

	localparam logic [ADDR_W-1:0] SUBNET_BASE_RST = 32'hC0A8_E200;
	localparam logic [ADDR_W-1:0] SUBNET_MASK_RST = 32'hFFFF_FF00;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_RED,
		ST_FIN
	} ssal_state_t;

endpackage
`default_nettype wire

>>> hdl/ssal_cell.sv
`default_nettype none
module ssal_cell
	import ssal_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              shift_en,
	input  wire logic [ADDR_W-1:0] prev_entry,
	input  wire logic [ADDR_W-1:0] key,
	input  wire logic              slot_valid,
	output logic      [ADDR_W-1:0] entry,
	output logic                   hit_s2
);

	logic [ADDR_W-1:0] entry_q;

	// on insert each cell takes prev_entry: its left neighbor's word, or the key for cell 0
	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= prev_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s2 <= 1'b0;
		end else begin
			hit_s2 <= slot_valid && (entry_q == key);
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

>>> hdl/subnet_source_address_learner.sv
`default_nettype none
// result strobe (done) is registered from ST_FIN, after an accepted start passes ST_CMP and ST_RED
// a new word is accepted only in ST_IDLE; busy is high in ST_CMP, ST_RED and ST_FIN after accept
// stages: per-cell compare, grouped or of 8 hits, final or with table update
// the result register drives done for exactly one cycle; receiver cannot stall
// reset: table empty, subnet registers to 192.168.226.0/24, entry contents kept
module subnet_source_address_learner
	import ssal_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [ETYPE_W-1:0]     eth_type,
	input  wire logic [ADDR_W-1:0]      src_addr,
	input  wire logic                   wr_en,
	input  wire logic [REG_IDX_W-1:0]   wr_index,
	input  wire logic [REG_DATA_W-1:0]  wr_data,
	output logic                        done,
	output logic                        is_new,
	output logic                        stored,
	output logic      [ADDR_W-1:0]      reported_addr,
	output logic      [COUNT_OUT_W-1:0] entry_count
);

	ssal_state_t state_q, state_next;

	logic [ADDR_W-1:0] base_q, mask_q;
	logic [ADDR_W-1:0] key_q;
	logic              counted_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              accept;
	logic              shift_en;
	logic              any_hit;
	logic              new_now;
	logic              store_now;
	logic [CNT_W-1:0]  cnt_next;
	logic [CNT_W+COUNT_OUT_W-1:0] cnt_wide;

	logic [TABLE_DEPTH-1:0]       hit_s2;
	logic [TABLE_DEPTH-1:0]       slot_valid;
	logic [NGRP*GRP-1:0]          hit_pad;
	logic [NGRP-1:0]              grp_s3;
	logic [ADDR_W-1:0]            entries [TABLE_DEPTH];

	logic                         done_q, is_new_q, stored_q;
	logic [ADDR_W-1:0]            rep_q;
	logic [COUNT_OUT_W-1:0]       cnt_out_q;

	assign accept = start && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= SUBNET_BASE_RST;
			mask_q <= SUBNET_MASK_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SUBNET_BASE: base_q <= wr_data;
				REG_SUBNET_MASK: mask_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q     <= src_addr;
			counted_q <= (eth_type == ETHERTYPE_IPV4) &&
				((src_addr & mask_q) == (base_q & mask_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_next = ST_CMP;
			ST_CMP:  state_next = ST_RED;
			ST_RED:  state_next = ST_FIN;
			ST_FIN:  state_next = ST_IDLE;
			default: state_next = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// row of cells, newest entry in cell 0
	genvar i;
	generate
		for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
			assign slot_valid[i] = (cnt_q > CNT_W'(i));
			if (i == 0) begin : g_head
				ssal_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.shift_en   (shift_en),
					.prev_entry (key_q),
					.key        (key_q),
					.slot_valid (slot_valid[i]),
					.entry      (entries[i]),
					.hit_s2     (hit_s2[i])
				);
			end else begin : g_body
				ssal_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.shift_en   (shift_en),
					.prev_entry (entries[i-1]),
					.key        (key_q),
					.slot_valid (slot_valid[i]),
					.entry      (entries[i]),
					.hit_s2     (hit_s2[i])
				);
			end
		end
	endgenerate

	assign hit_pad = (NGRP*GRP)'(hit_s2);

	genvar g;
	generate
		for (g = 0; g < NGRP; g++) begin : g_grp
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					grp_s3[g] <= 1'b0;
				end else begin
					grp_s3[g] <= |hit_pad[g*GRP +: GRP];
				end
			end
		end
	endgenerate

	assign any_hit   = |grp_s3;
	assign new_now   = counted_q && !any_hit;
	assign store_now = new_now && (cnt_q < CNT_W'(TABLE_DEPTH));
	assign shift_en  = (state_q == ST_FIN) && store_now;
	assign cnt_next  = store_now ? cnt_q + CNT_W'(1) : cnt_q;
	assign cnt_wide  = (CNT_W+COUNT_OUT_W)'(cnt_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FIN);
			if (shift_en) begin
				cnt_q <= cnt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			is_new_q  <= new_now;
			stored_q  <= store_now;
			rep_q     <= key_q;
			cnt_out_q <= cnt_wide[COUNT_OUT_W-1:0];
		end
	end

	assign done          = done_q;
	assign is_new        = is_new_q;
	assign stored        = stored_q;
	assign reported_addr = rep_q;
	assign entry_count   = cnt_out_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while busy");

	a_stored_new: assert property (@(posedge clk) disable iff (!arst_n)
		(done && stored) |-> is_new)
		else $error("stored word not flagged new");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted word did not raise busy");

endmodule
`default_nettype wire
